FILE: rtl/pqa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqa_pkg;

  localparam int SEQ_W       = 32;
  localparam int WORD_W      = 32;
  localparam int PRIO_W      = 2;
  localparam int SERVE_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_TUSER_W = 2;

  localparam logic [SERVE_W-1:0] SERVE_MAX = '1;

  typedef enum logic [0:0] {
    REG_AGING_ENABLE    = 1'b0,
    REG_AGING_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

endpackage

`default_nettype wire

FILE: rtl/pqa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pqa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/priority_queue_with_aging_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Timing: a push result and a failed pop result are presented in the cycle after their input
// beat; a successful pop result passes through the read register of the single task memory
// and then the output register. Throughput: an input beat is taken while no pop read is
// pending and the output register is empty or being drained, so one push per cycle under
// that condition; a successful pop blocks input beats while its memory read is pending.
// Reset (rst_n low, synchronous) empties all levels and clears sequence, serve and
// promotion counters; aging is off and the threshold is 1. No memory clearing pass.
module priority_queue_with_aging_core #(
  parameter int LEVEL_DEPTH     = 16,
  parameter int PRIORITY_LEVELS = 3,
  parameter int PAYLOAD_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire pqa_pkg::cfg_reg_t                   cfg_index,
  input  wire logic [pqa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic                                in_tuser,  // [0] req_type
  input  wire logic [pqa_pkg::IN_TDATA_W-1:0]      in_tdata,  // [1:0] task_priority,
                                                              // [33:2] task_payload
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [pqa_pkg::OUT_TUSER_W-1:0]     out_tuser, // [0] ok, [1] promoted
  output logic      [pqa_pkg::OUT_TDATA_W-1:0]     out_tdata  // [31:0] out_payload,
                                                              // [33:32] out_priority,
                                                              // [65:34] out_sequence,
                                                              // [97:66] served_total,
                                                              // [129:98] promotions_total
);

  import pqa_pkg::*;

  localparam int LW     = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int SW     = $clog2(LEVEL_DEPTH);
  localparam int CW     = $clog2(LEVEL_DEPTH + 1);
  localparam int AW     = LW + SW;
  localparam int MDEPTH = PRIORITY_LEVELS * (2 ** SW);
  localparam int MW     = SEQ_W + PAYLOAD_WIDTH;

  localparam logic [CW-1:0] FULL_CNT  = CW'(LEVEL_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(LEVEL_DEPTH - 1);

  // per-level ring pointers and fill counts
  logic [SW-1:0] head_r  [PRIORITY_LEVELS];
  logic [SW-1:0] head_nxt[PRIORITY_LEVELS];
  logic [SW-1:0] tail_r  [PRIORITY_LEVELS];
  logic [SW-1:0] tail_nxt[PRIORITY_LEVELS];
  logic [CW-1:0] cnt_r   [PRIORITY_LEVELS];
  logic [CW-1:0] cnt_nxt [PRIORITY_LEVELS];

  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [SERVE_W-1:0] serves_r, serves_nxt;
  logic [WORD_W-1:0]  served_r, served_nxt;
  logic [WORD_W-1:0]  promo_cnt_r, promo_cnt_nxt;
  logic               aging_en_r, aging_en_nxt;
  logic [SERVE_W-1:0] thr_r, thr_nxt;
  logic               rd_pend_r, rd_pend_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_promo_r, out_promo_nxt;
  logic [WORD_W-1:0]  out_pay_r, out_pay_nxt;
  logic [PRIO_W-1:0]  out_prio_r, out_prio_nxt;
  logic [SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic [WORD_W-1:0]  out_served_r, out_served_nxt;
  logic [WORD_W-1:0]  out_promos_r, out_promos_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic               in_accept;
  logic [PRIO_W-1:0]  in_prio;
  logic [WORD_W-1:0]  in_pay;
  logic [SERVE_W-1:0] thr_eff;
  logic               aging_due;
  logic               norm_hit, age_hit, pop_hit, pop_promo;
  logic [LW-1:0]      norm_lvl, age_lvl, pop_lvl, push_lvl;
  logic               prio_ok, push_ok;
  logic [CW-1:0]      push_cnt;
  logic [SW-1:0]      push_tail, pop_head;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !rd_pend_r && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;
  assign in_prio    = in_tdata[PRIO_W-1:0];
  assign in_pay     = in_tdata[PRIO_W +: WORD_W];

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_promo_r, out_ok_r};
  assign out_tdata  = {6'd0, out_promos_r, out_served_r, out_seq_r, out_prio_r, out_pay_r};

  pqa_ram #(
    .WIDTH(MW),
    .DEPTH(MDEPTH)
  ) u_task_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // level selection
  always_comb begin
    thr_eff   = (thr_r == '0) ? SERVE_W'(1) : thr_r;
    aging_due = aging_en_r && (serves_r >= thr_eff);

    // lowest occupied level wins on the normal path
    norm_hit = 1'b0;
    norm_lvl = '0;
    for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        norm_hit = 1'b1;
        norm_lvl = LW'(l);
      end
    end

    // highest occupied level above 0 wins on promotion
    age_hit = 1'b0;
    age_lvl = '0;
    for (int l = 1; l < PRIORITY_LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        age_hit = 1'b1;
        age_lvl = LW'(l);
      end
    end

    pop_promo = aging_due && age_hit;
    pop_hit   = norm_hit;
    pop_lvl   = pop_promo ? age_lvl : norm_lvl;

    prio_ok  = int'(in_prio) < PRIORITY_LEVELS;
    push_lvl = LW'(in_prio);
    push_cnt  = FULL_CNT;
    push_tail = '0;
    pop_head  = '0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (LW'(l) == push_lvl) begin
        push_cnt  = cnt_r[l];
        push_tail = tail_r[l];
      end
      if (LW'(l) == pop_lvl) begin
        pop_head = head_r[l];
      end
    end
    push_ok = prio_ok && (push_cnt != FULL_CNT);
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    seq_nxt        = seq_r;
    serves_nxt     = serves_r;
    served_nxt     = served_r;
    promo_cnt_nxt  = promo_cnt_r;
    aging_en_nxt   = aging_en_r;
    thr_nxt        = thr_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_ok_nxt     = out_ok_r;
    out_promo_nxt  = out_promo_r;
    out_pay_nxt    = out_pay_r;
    out_prio_nxt   = out_prio_r;
    out_seq_nxt    = out_seq_r;
    out_served_nxt = out_served_r;
    out_promos_nxt = out_promos_r;
    ram_we         = 1'b0;
    ram_waddr      = {push_lvl, push_tail};
    ram_wdata      = {seq_r + SEQ_W'(1), in_pay[PAYLOAD_WIDTH-1:0]};
    ram_re         = 1'b0;
    ram_raddr      = {pop_lvl, pop_head};

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AGING_ENABLE:    aging_en_nxt = cfg_data[0];
        REG_AGING_THRESHOLD: thr_nxt      = cfg_data;
        default: ;
      endcase
    end

    // task word of a pop lands in the cycle after its read
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_pay_nxt   = WORD_W'(ram_rdata[PAYLOAD_WIDTH-1:0]);
      out_seq_nxt   = ram_rdata[PAYLOAD_WIDTH +: SEQ_W];
    end

    if (in_accept) begin
      out_pay_nxt   = '0;
      out_prio_nxt  = '0;
      out_seq_nxt   = '0;
      out_promo_nxt = 1'b0;
      if (in_tuser == REQ_PUSH) begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = push_ok;
        if (push_ok) begin
          seq_nxt     = seq_r + SEQ_W'(1);
          out_seq_nxt = seq_r + SEQ_W'(1);
          ram_we      = 1'b1;
          for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            if (LW'(l) == push_lvl) begin
              tail_nxt[l] = (tail_r[l] == LAST_SLOT) ? '0 : tail_r[l] + SW'(1);
              cnt_nxt[l]  = cnt_r[l] + CW'(1);
            end
          end
        end
        out_served_nxt = served_r;
        out_promos_nxt = promo_cnt_r;
      end else begin
        out_ok_nxt = pop_hit;
        if (pop_hit) begin
          // hold the beat until the memory returns the task word
          out_valid_nxt = 1'b0;
          rd_pend_nxt   = 1'b1;
          ram_re        = 1'b1;
          out_prio_nxt  = PRIO_W'(pop_lvl);
          out_promo_nxt = pop_promo;
          served_nxt    = served_r + WORD_W'(1);
          if (pop_promo) begin
            promo_cnt_nxt = promo_cnt_r + WORD_W'(1);
            serves_nxt    = '0;
          end else if (serves_r != SERVE_MAX) begin
            serves_nxt = serves_r + SERVE_W'(1);
          end
          for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            if (LW'(l) == pop_lvl) begin
              head_nxt[l] = (head_r[l] == LAST_SLOT) ? '0 : head_r[l] + SW'(1);
              cnt_nxt[l]  = cnt_r[l] - CW'(1);
            end
          end
        end else begin
          out_valid_nxt = 1'b1;
        end
        out_served_nxt = served_nxt;
        out_promos_nxt = promo_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      seq_r       <= '0;
      serves_r    <= '0;
      served_r    <= '0;
      promo_cnt_r <= '0;
      aging_en_r  <= 1'b0;
      thr_r       <= SERVE_W'(1);
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      seq_r       <= seq_nxt;
      serves_r    <= serves_nxt;
      served_r    <= served_nxt;
      promo_cnt_r <= promo_cnt_nxt;
      aging_en_r  <= aging_en_nxt;
      thr_r       <= thr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r     <= out_ok_nxt;
    out_promo_r  <= out_promo_nxt;
    out_pay_r    <= out_pay_nxt;
    out_prio_r   <= out_prio_nxt;
    out_seq_r    <= out_seq_nxt;
    out_served_r <= out_served_nxt;
    out_promos_r <= out_promos_nxt;
  end

  a_read_then_beat: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("pop read did not produce a result beat");

  a_push_next_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == REQ_PUSH) |=> out_valid_r && !rd_pend_r)
    else $error("push result not presented on the next cycle");

  a_read_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> out_ok_r)
    else $error("memory read pending without a successful pop");

  a_promo_from_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_promo_r |-> out_ok_r && (out_prio_r != '0))
    else $error("promotion served from level 0 or failed");

endmodule

`default_nettype wire
